>>> rtl/core/balloc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// balloc_pkg
// Shared constants, codes and types of the three-quarter buddy allocator.
// ----------------------------------------------------------------------------
package balloc_pkg;

  localparam int LOG_TOTAL   = 12;
  localparam int TOTAL_UNITS = 1 << LOG_TOTAL;
  localparam int LEVELS      = LOG_TOTAL + 1;
  localparam int OFF_W       = LOG_TOTAL;
  localparam int LV_W        = 4;
  localparam int SIZE_W      = 13;
  localparam int CNT_W       = 13;
  localparam int LINK_W      = OFF_W + 1;
  localparam int PADDR_W     = 3;

  localparam logic [LINK_W-1:0] NIL       = LINK_W'(TOTAL_UNITS);
  localparam logic [CNT_W-1:0]  COUNT_MAX = CNT_W'(8191);

  localparam logic       OP_ALLOC = 1'b0;
  localparam logic       OP_FREE  = 1'b1;

  localparam logic [1:0] STAT_GRANT = 2'd0;
  localparam logic [1:0] STAT_NOMEM = 2'd1;
  localparam logic [1:0] STAT_FREED = 2'd2;

  localparam logic       REG_HALF_SPLIT = 1'b0;
  localparam logic       REG_THREE_QTR  = 1'b1;

  typedef struct packed {
    logic            start;
    logic            free;
    logic [LV_W-1:0] lg;
  } map_t;

  localparam map_t MAP_INIT = '{start: 1'b1, free: 1'b1, lg: LV_W'(LOG_TOTAL)};

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_SEARCH,
    CMD_LV_DEC,
    CMD_SET_BASE,
    CMD_MOVE_RIGHT,
    CMD_MOVE_UP,
    CMD_UNL_WR,
    CMD_BM_FREE,
    CMD_BM_TAKEN,
    CMD_BM_ZERO,
    CMD_PF_1,
    CMD_PF_2,
    CMD_PB_1,
    CMD_PB_2,
    CMD_CNT_ALLOC,
    CMD_CNT_FREE,
    CMD_EMIT_NOMEM,
    CMD_EMIT_FREED,
    CMD_EMIT_WHOLE,
    CMD_EMIT_HALF,
    CMD_EMIT_QTR
  } cmd_e;

  typedef enum logic [2:0] {
    SEL_CUR,
    SEL_LEFT_DN,
    SEL_RIGHT_DN,
    SEL_BASE,
    SEL_BUDDY,
    SEL_HIGH
  } sel_e;

  typedef enum logic [1:0] {
    PH_HALF,
    PH_TQ1,
    PH_TQ2
  } split_ph_e;

  typedef enum logic [1:0] {
    TK_WHOLE,
    TK_BASE,
    TK_QTR
  } take_e;

  typedef enum logic [5:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_SEARCH, S_DECIDE,
    S_SP_RD, S_SP_WR, S_SP_BML, S_SP_BMR,
    S_SP_PFL1, S_SP_PFL2, S_SP_PFR1, S_SP_PFR2, S_SP_END,
    S_TK_RD, S_TK_WR, S_TK_BM, S_CNT_ALLOC,
    S_EMIT_NOMEM, S_EMIT_WHOLE, S_EMIT_HALF, S_EMIT_QTR, S_EMIT_FREED,
    S_FR_CHK, S_FR_VAL, S_FR_BM, S_FR_PB1, S_FR_PB2,
    S_MG_CHK, S_MG_VAL, S_MG_U1R, S_MG_U1W, S_MG_U2R, S_MG_U2W,
    S_MG_HI, S_MG_UP, S_MG_BM, S_MG_PF1, S_MG_PF2
  } ctl_state_e;

  typedef struct packed {
    cmd_e op;
    sel_e sel;
    logic in_ready;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic op_free;
    logic size_zero;
    logic found;
    logic can_half;
    logic can_tq;
    logic pre_ok;
    logic blk_ok;
    logic buddy_ok;
    logic at_top;
    logic out_full;
    logic clr_done;
  } ctl_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/balloc_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// balloc_req_if
// Request channel: allocate or free transactions with valid/ready.
// ----------------------------------------------------------------------------
interface balloc_req_if import balloc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [SIZE_W-1:0] req_units;
  logic [OFF_W-1:0]  block_offset;
  logic [LV_W-1:0]   block_log_size;
  logic              last_block;

  modport source (output valid, operation, req_units, block_offset, block_log_size,
                  last_block, input ready);
  modport sink   (input valid, operation, req_units, block_offset, block_log_size,
                  last_block, output ready);
endinterface
`default_nettype wire

>>> rtl/core/balloc_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// balloc_rsp_if
// Result channel: grant, refusal and free-done transactions with valid/ready.
// ----------------------------------------------------------------------------
interface balloc_rsp_if import balloc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [OFF_W-1:0] granted_offset;
  logic [LV_W-1:0]  granted_log_size;
  logic             last;
  logic [CNT_W-1:0] requested_total;
  logic [CNT_W-1:0] allocated_total;

  modport source (output valid, status, granted_offset, granted_log_size, last,
                  requested_total, allocated_total, input ready);
  modport sink   (input valid, status, granted_offset, granted_log_size, last,
                  requested_total, allocated_total, output ready);
endinterface
`default_nettype wire

>>> rtl/core/balloc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// balloc_dp
// Datapath: block map and link memories, list ends, totals, config, result reg.
// ----------------------------------------------------------------------------
module balloc_dp import balloc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready,
  balloc_req_if.sink              req_i,
  balloc_rsp_if.source            rsp_o,
  input  wire ctl_cmd_t           cmd_i,
  output      ctl_sts_t           sts_o
);

  logic              op_q, last_q, tq_q, hs_q, tqe_q;
  logic [SIZE_W-1:0] size_q;
  logic [OFF_W-1:0]  off_q, base_q;
  logic [LV_W-1:0]   lv_q;
  logic [CNT_W-1:0]  req_cnt_q, alloc_cnt_q;
  logic [LINK_W-1:0] head_q [LEVELS];
  logic [LINK_W-1:0] tail_q [LEVELS];
  logic [LINK_W-1:0] h_q;
  logic [OFF_W-1:0]  clr_cnt_q;
  logic              clr_done_q;

  logic              out_valid_q, out_last_q;
  logic [1:0]        out_status_q;
  logic [OFF_W-1:0]  out_off_q;
  logic [LV_W-1:0]   out_lv_q;
  logic [CNT_W-1:0]  out_req_q, out_alloc_q;

  map_t              bm_mem [TOTAL_UNITS];
  logic [LINK_W-1:0] nx_mem [TOTAL_UNITS];
  logic [LINK_W-1:0] pv_mem [TOTAL_UNITS];
  map_t              bm_rd_q;
  logic [LINK_W-1:0] nx_rd_q, pv_rd_q;

  logic              bm_we, nx_we, pv_we;
  logic [OFF_W-1:0]  bm_wa, nx_wa, pv_wa;
  map_t              bm_wd;
  logic [LINK_W-1:0] nx_wd, pv_wd;

  logic [LV_W-1:0]   t_lv;
  logic [OFF_W-1:0]  t_off, half, lvbit;
  logic [SIZE_W-1:0] blk, gamt;
  logic [LINK_W-1:0] t_link, lh, lt;
  logic              req_fire, cfg_we;
  logic [LEVELS-1:0] fits;
  logic [LV_W-1:0]   fnd_lv;

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_sub(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
    return (b > a) ? '0 : a - b;
  endfunction

  assign req_fire    = req_i.valid && cmd_i.in_ready;
  assign req_i.ready = cmd_i.in_ready;

  // config port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_THREE_QTR) ? {31'b0, tqe_q} : {31'b0, hs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_q  <= 1'b1;
      tqe_q <= 1'b1;
    end else if (cfg_we) begin
      if (paddr[2] == REG_HALF_SPLIT) hs_q <= pwdata[0];
      else tqe_q <= pwdata[0];
    end
  end

  assign blk   = SIZE_W'(1) << lv_q;
  assign half  = (lv_q != '0) ? (OFF_W'(1) << (lv_q - LV_W'(1))) : '0;
  assign lvbit = OFF_W'(1) << lv_q;
  assign gamt  = tq_q ? (blk + (blk >> 1)) : blk;

  // operand of the current list or map access
  always_comb begin
    t_lv  = lv_q;
    t_off = off_q;
    case (cmd_i.sel)
      SEL_CUR:      begin t_lv = lv_q;           t_off = off_q;         end
      SEL_LEFT_DN:  begin t_lv = lv_q - LV_W'(1); t_off = off_q;         end
      SEL_RIGHT_DN: begin t_lv = lv_q - LV_W'(1); t_off = off_q + half;  end
      SEL_BASE:     begin t_lv = lv_q;           t_off = base_q;        end
      SEL_BUDDY:    begin t_lv = lv_q;           t_off = off_q ^ lvbit; end
      SEL_HIGH:     begin t_lv = lv_q;           t_off = off_q | lvbit; end
      default:      begin t_lv = lv_q;           t_off = off_q;         end
    endcase
  end

  assign t_link = {1'b0, t_off};
  assign lh     = head_q[t_lv];
  assign lt     = tail_q[t_lv];

  // smallest non-empty level that fits
  always_comb begin
    fnd_lv = '0;
    for (int i = 0; i < LEVELS; i++) begin
      fits[i] = ((SIZE_W'(1) << i) >= size_q) && (head_q[i] != NIL);
    end
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (fits[i]) fnd_lv = LV_W'(i);
    end
  end

  // memory write decode
  always_comb begin
    bm_we = 1'b0; bm_wa = t_off; bm_wd = '0;
    nx_we = 1'b0; nx_wa = t_off; nx_wd = NIL;
    pv_we = 1'b0; pv_wa = t_off; pv_wd = NIL;
    unique case (cmd_i.op)
      CMD_CLEAR: begin
        bm_we = 1'b1;
        bm_wa = clr_cnt_q;
        bm_wd = (clr_cnt_q == '0) ? MAP_INIT : '0;
        nx_we = (clr_cnt_q == '0);
        pv_we = (clr_cnt_q == '0);
        nx_wa = '0;
        pv_wa = '0;
      end
      CMD_BM_FREE:  begin bm_we = 1'b1; bm_wd = '{start: 1'b1, free: 1'b1, lg: t_lv}; end
      CMD_BM_TAKEN: begin bm_we = 1'b1; bm_wd = '{start: 1'b1, free: 1'b0, lg: t_lv}; end
      CMD_BM_ZERO:  begin bm_we = 1'b1; bm_wd = '0; end
      CMD_UNL_WR: begin
        nx_we = (pv_rd_q != NIL);
        nx_wa = pv_rd_q[OFF_W-1:0];
        nx_wd = nx_rd_q;
        pv_we = (nx_rd_q != NIL);
        pv_wa = nx_rd_q[OFF_W-1:0];
        pv_wd = pv_rd_q;
      end
      CMD_PF_1: begin
        nx_we = 1'b1; nx_wd = lh;
        pv_we = 1'b1; pv_wd = NIL;
      end
      CMD_PF_2: begin
        pv_we = (h_q != NIL); pv_wa = h_q[OFF_W-1:0]; pv_wd = t_link;
      end
      CMD_PB_1: begin
        pv_we = 1'b1; pv_wd = lt;
        nx_we = 1'b1; nx_wd = NIL;
      end
      CMD_PB_2: begin
        nx_we = (h_q != NIL); nx_wa = h_q[OFF_W-1:0]; nx_wd = t_link;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (bm_we) bm_mem[bm_wa] <= bm_wd;
    bm_rd_q <= bm_mem[t_off];
  end

  always_ff @(posedge clk_i) begin
    if (nx_we) nx_mem[nx_wa] <= nx_wd;
    nx_rd_q <= nx_mem[t_off];
  end

  always_ff @(posedge clk_i) begin
    if (pv_we) pv_mem[pv_wa] <= pv_wd;
    pv_rd_q <= pv_mem[t_off];
  end

  // list ends and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_q[i] <= (i == LOG_TOTAL) ? '0 : NIL;
        tail_q[i] <= (i == LOG_TOTAL) ? '0 : NIL;
      end
      req_cnt_q   <= '0;
      alloc_cnt_q <= '0;
      clr_cnt_q   <= '0;
      clr_done_q  <= 1'b0;
      tq_q        <= 1'b0;
      out_valid_q <= 1'b0;
      out_req_q   <= '0;
      out_alloc_q <= '0;
    end else begin
      if (rsp_o.valid && rsp_o.ready) out_valid_q <= 1'b0;
      if (req_fire) tq_q <= 1'b0;
      unique case (cmd_i.op)
        CMD_CLEAR: begin
          if (clr_cnt_q == OFF_W'(TOTAL_UNITS - 1)) clr_done_q <= 1'b1;
          else clr_cnt_q <= clr_cnt_q + OFF_W'(1);
        end
        CMD_SET_BASE: tq_q <= 1'b1;
        CMD_UNL_WR: begin
          if (pv_rd_q == NIL) head_q[t_lv] <= nx_rd_q;
          if (nx_rd_q == NIL) tail_q[t_lv] <= pv_rd_q;
        end
        CMD_PF_1: begin
          head_q[t_lv] <= t_link;
          if (lh == NIL) tail_q[t_lv] <= t_link;
        end
        CMD_PB_1: begin
          tail_q[t_lv] <= t_link;
          if (lt == NIL) head_q[t_lv] <= t_link;
        end
        CMD_CNT_ALLOC: begin
          req_cnt_q   <= sat_add(req_cnt_q, size_q);
          alloc_cnt_q <= sat_add(alloc_cnt_q, gamt);
        end
        CMD_CNT_FREE: begin
          alloc_cnt_q <= sat_sub(alloc_cnt_q, blk);
          if (last_q) req_cnt_q <= sat_sub(req_cnt_q, size_q);
        end
        // totals are frozen with the result so a later item cannot move them
        CMD_EMIT_NOMEM, CMD_EMIT_FREED, CMD_EMIT_WHOLE,
        CMD_EMIT_HALF, CMD_EMIT_QTR: begin
          out_valid_q <= 1'b1;
          out_req_q   <= req_cnt_q;
          out_alloc_q <= alloc_cnt_q;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q   <= req_i.operation;
      size_q <= req_i.req_units;
      off_q  <= req_i.block_offset;
      lv_q   <= req_i.block_log_size;
      last_q <= req_i.last_block;
    end
    unique case (cmd_i.op)
      CMD_SEARCH: begin
        lv_q  <= fnd_lv;
        off_q <= head_q[fnd_lv][OFF_W-1:0];
      end
      CMD_LV_DEC:     lv_q <= lv_q - LV_W'(1);
      CMD_SET_BASE:   base_q <= off_q;
      CMD_MOVE_RIGHT: begin
        off_q <= off_q + half;
        lv_q  <= lv_q - LV_W'(1);
      end
      CMD_MOVE_UP: begin
        off_q <= off_q & ~lvbit;
        lv_q  <= lv_q + LV_W'(1);
      end
      CMD_PF_1: h_q <= lh;
      CMD_PB_1: h_q <= lt;
      CMD_EMIT_NOMEM: begin
        out_status_q <= STAT_NOMEM; out_off_q <= '0; out_lv_q <= '0; out_last_q <= 1'b1;
      end
      CMD_EMIT_FREED: begin
        out_status_q <= STAT_FREED; out_off_q <= '0; out_lv_q <= '0; out_last_q <= 1'b1;
      end
      CMD_EMIT_WHOLE: begin
        out_status_q <= STAT_GRANT; out_off_q <= off_q; out_lv_q <= lv_q; out_last_q <= 1'b1;
      end
      CMD_EMIT_HALF: begin
        out_status_q <= STAT_GRANT; out_off_q <= base_q; out_lv_q <= lv_q;
        out_last_q   <= 1'b0;
      end
      CMD_EMIT_QTR: begin
        out_status_q <= STAT_GRANT; out_off_q <= off_q; out_lv_q <= lv_q - LV_W'(1);
        out_last_q   <= 1'b1;
      end
      default: ;
    endcase
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.status           = out_status_q;
  assign rsp_o.granted_offset   = out_off_q;
  assign rsp_o.granted_log_size = out_lv_q;
  assign rsp_o.last             = out_last_q;
  assign rsp_o.requested_total  = out_req_q;
  assign rsp_o.allocated_total  = out_alloc_q;

  always_comb begin
    sts_o.in_valid  = req_i.valid;
    sts_o.op_free   = (op_q == OP_FREE);
    sts_o.size_zero = (size_q == '0);
    sts_o.found     = |fits;
    sts_o.can_half  = hs_q && (lv_q >= LV_W'(1)) && ({1'b0, blk} >= {size_q, 1'b0});
    sts_o.can_tq    = tqe_q && (lv_q >= LV_W'(2)) &&
                      (({2'b0, blk} + {1'b0, blk, 1'b0}) >= {size_q, 2'b00});
    sts_o.pre_ok    = (lv_q <= LV_W'(LOG_TOTAL)) &&
                      ((off_q & OFF_W'(blk - SIZE_W'(1))) == '0);
    sts_o.blk_ok    = bm_rd_q.start && !bm_rd_q.free && (bm_rd_q.lg == lv_q);
    sts_o.buddy_ok  = bm_rd_q.start && bm_rd_q.free && (bm_rd_q.lg == lv_q);
    sts_o.at_top    = (lv_q == LV_W'(LOG_TOTAL));
    sts_o.out_full  = out_valid_q;
    sts_o.clr_done  = clr_done_q;
  end

endmodule
`default_nettype wire

>>> rtl/core/balloc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// balloc_ctrl
// Sequencer for search, split, take, free and merge steps of the allocator.
// ----------------------------------------------------------------------------
module balloc_ctrl import balloc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire ctl_sts_t sts_i,
  output      ctl_cmd_t cmd_o
);

  ctl_state_e state_q, state_d;
  split_ph_e  phase_q, phase_d;
  take_e      take_q, take_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      phase_q <= PH_HALF;
      take_q  <= TK_WHOLE;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      take_q  <= take_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    phase_d        = phase_q;
    take_d         = take_q;
    cmd_o.op       = CMD_NONE;
    cmd_o.sel      = SEL_CUR;
    cmd_o.in_ready = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        if (sts_i.clr_done) state_d = S_IDLE;
        else cmd_o.op = CMD_CLEAR;
      end
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) state_d = S_DISPATCH;
      end
      S_DISPATCH: state_d = sts_i.op_free ? S_FR_CHK : S_SEARCH;
      S_SEARCH: begin
        if (sts_i.size_zero || !sts_i.found) state_d = S_EMIT_NOMEM;
        else begin
          cmd_o.op = CMD_SEARCH;
          state_d  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.can_half) begin
          phase_d = PH_HALF;
          state_d = S_SP_RD;
        end else if (sts_i.can_tq) begin
          cmd_o.op = CMD_SET_BASE;
          phase_d  = PH_TQ1;
          state_d  = S_SP_RD;
        end else begin
          take_d  = TK_WHOLE;
          state_d = S_TK_RD;
        end
      end
      // split: unlink, mark both halves free, push left then right to the front
      S_SP_RD:   state_d = S_SP_WR;
      S_SP_WR:   begin cmd_o.op = CMD_UNL_WR; state_d = S_SP_BML; end
      S_SP_BML:  begin cmd_o.op = CMD_BM_FREE; cmd_o.sel = SEL_LEFT_DN;  state_d = S_SP_BMR;  end
      S_SP_BMR:  begin cmd_o.op = CMD_BM_FREE; cmd_o.sel = SEL_RIGHT_DN; state_d = S_SP_PFL1; end
      S_SP_PFL1: begin cmd_o.op = CMD_PF_1; cmd_o.sel = SEL_LEFT_DN;  state_d = S_SP_PFL2; end
      S_SP_PFL2: begin cmd_o.op = CMD_PF_2; cmd_o.sel = SEL_LEFT_DN;  state_d = S_SP_PFR1; end
      S_SP_PFR1: begin cmd_o.op = CMD_PF_1; cmd_o.sel = SEL_RIGHT_DN; state_d = S_SP_PFR2; end
      S_SP_PFR2: begin cmd_o.op = CMD_PF_2; cmd_o.sel = SEL_RIGHT_DN; state_d = S_SP_END;  end
      S_SP_END: begin
        unique case (phase_q)
          PH_HALF: begin
            cmd_o.op = CMD_LV_DEC;
            state_d  = S_DECIDE;
          end
          PH_TQ1: begin
            cmd_o.op = CMD_MOVE_RIGHT;
            phase_d  = PH_TQ2;
            state_d  = S_SP_RD;
          end
          default: begin
            take_d  = TK_BASE;
            state_d = S_TK_RD;
          end
        endcase
      end
      S_TK_RD, S_TK_WR, S_TK_BM: begin
        unique case (take_q)
          TK_BASE: cmd_o.sel = SEL_BASE;
          TK_QTR:  cmd_o.sel = SEL_LEFT_DN;
          default: cmd_o.sel = SEL_CUR;
        endcase
        if (state_q == S_TK_RD) state_d = S_TK_WR;
        else if (state_q == S_TK_WR) begin
          cmd_o.op = CMD_UNL_WR;
          state_d  = S_TK_BM;
        end else begin
          cmd_o.op = CMD_BM_TAKEN;
          if (take_q == TK_BASE) begin
            take_d  = TK_QTR;
            state_d = S_TK_RD;
          end else state_d = S_CNT_ALLOC;
        end
      end
      S_CNT_ALLOC: begin
        cmd_o.op = CMD_CNT_ALLOC;
        state_d  = (take_q == TK_WHOLE) ? S_EMIT_WHOLE : S_EMIT_HALF;
      end
      S_EMIT_NOMEM: if (!sts_i.out_full) begin cmd_o.op = CMD_EMIT_NOMEM; state_d = S_IDLE; end
      S_EMIT_WHOLE: if (!sts_i.out_full) begin cmd_o.op = CMD_EMIT_WHOLE; state_d = S_IDLE; end
      S_EMIT_HALF:  if (!sts_i.out_full) begin cmd_o.op = CMD_EMIT_HALF; state_d = S_EMIT_QTR; end
      S_EMIT_QTR:   if (!sts_i.out_full) begin cmd_o.op = CMD_EMIT_QTR; state_d = S_IDLE; end
      S_EMIT_FREED: if (!sts_i.out_full) begin cmd_o.op = CMD_EMIT_FREED; state_d = S_IDLE; end
      // free: check, return to back of list, then merge upwards
      S_FR_CHK: state_d = sts_i.pre_ok ? S_FR_VAL : S_EMIT_FREED;
      S_FR_VAL: begin
        if (sts_i.blk_ok) begin
          cmd_o.op = CMD_CNT_FREE;
          state_d  = S_FR_BM;
        end else state_d = S_EMIT_FREED;
      end
      S_FR_BM:  begin cmd_o.op = CMD_BM_FREE; state_d = S_FR_PB1; end
      S_FR_PB1: begin cmd_o.op = CMD_PB_1; state_d = S_FR_PB2; end
      S_FR_PB2: begin cmd_o.op = CMD_PB_2; state_d = S_MG_CHK; end
      S_MG_CHK: begin
        cmd_o.sel = SEL_BUDDY;
        state_d   = sts_i.at_top ? S_EMIT_FREED : S_MG_VAL;
      end
      S_MG_VAL: state_d = sts_i.buddy_ok ? S_MG_U1R : S_EMIT_FREED;
      S_MG_U1R: state_d = S_MG_U1W;
      S_MG_U1W: begin cmd_o.op = CMD_UNL_WR; state_d = S_MG_U2R; end
      S_MG_U2R: begin cmd_o.sel = SEL_BUDDY; state_d = S_MG_U2W; end
      S_MG_U2W: begin cmd_o.op = CMD_UNL_WR; cmd_o.sel = SEL_BUDDY; state_d = S_MG_HI; end
      S_MG_HI:  begin cmd_o.op = CMD_BM_ZERO; cmd_o.sel = SEL_HIGH; state_d = S_MG_UP; end
      S_MG_UP:  begin cmd_o.op = CMD_MOVE_UP; state_d = S_MG_BM; end
      S_MG_BM:  begin cmd_o.op = CMD_BM_FREE; state_d = S_MG_PF1; end
      S_MG_PF1: begin cmd_o.op = CMD_PF_1; state_d = S_MG_PF2; end
      S_MG_PF2: begin cmd_o.op = CMD_PF_2; state_d = S_MG_CHK; end
      default:  state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/buddy_allocator_three_quarter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_allocator_three_quarter
// Buddy allocator with half-split and half-plus-quarter grants over 4096 units.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 4096-entry block map and takes no
// transaction until that is done (configuration writes are taken).
// One item is handled at a time. An allocate that grants a whole block may
// first halve it by splits; a half-plus-quarter grant adds two splits, two
// takes and a second result. A valid free may end in buddy merges. Each
// result also waits for the output register to be free. The block map and
// link memories have one read and one write port with registered read data,
// so each list edit is a read followed by one or two writes.
module buddy_allocator_three_quarter import balloc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready,
  balloc_req_if.sink              req_i,
  balloc_rsp_if.source            rsp_o
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  balloc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  balloc_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_i),
    .rsp_o   (rsp_o),
    .cmd_i   (cmd),
    .sts_o   (sts)
  );

endmodule
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Allocate/free traffic against a buddy allocator model with split modes.
// ----------------------------------------------------------------------------
module tb_top;
  import balloc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  balloc_req_if req_if ();
  balloc_rsp_if rsp_if ();

  buddy_allocator_three_quarter uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_i(req_if.sink), .rsp_o(rsp_if.source)
  );

  typedef struct packed {
    logic [1:0]       status;
    logic [OFF_W-1:0] offset;
    logic [LV_W-1:0]  lg;
    logic             last;
    logic [CNT_W-1:0] req_tot;
    logic [CNT_W-1:0] alloc_tot;
  } grant_t;

  typedef struct {
    int unsigned off;
    int unsigned lg;
    int unsigned size;
    bit          last;
  } live_blk_t;

  // allocator shadow state
  logic        sh_start [TOTAL_UNITS];
  logic        sh_free [TOTAL_UNITS];
  int unsigned sh_lg [TOTAL_UNITS];
  int unsigned sh_next [TOTAL_UNITS];
  int unsigned sh_prev [TOTAL_UNITS];
  int unsigned lv_head [LEVELS];
  int unsigned lv_tail [LEVELS];
  int unsigned req_cnt, alloc_cnt;
  bit half_en, tq_en;

  grant_t     expected_grants[$];
  live_blk_t  live_blocks[$];
  int unsigned errors = 0;
  int unsigned mismatches = 0;
  bit rsp_hold = 1'b0;
  bit sweep = 1'b0;

  initial forever #1 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

  // ---------------- shadow model ----------------
  function automatic void lst_unlink(int unsigned lv, int unsigned off);
    int unsigned p, n;
    p = sh_prev[off];
    n = sh_next[off];
    if (p == NIL) lv_head[lv] = n;
    else sh_next[p] = n;
    if (n == NIL) lv_tail[lv] = p;
    else sh_prev[n] = p;
  endfunction

  function automatic void lst_front(int unsigned lv, int unsigned off);
    int unsigned h;
    h = lv_head[lv];
    sh_prev[off] = NIL;
    sh_next[off] = h;
    if (h == NIL) lv_tail[lv] = off;
    else sh_prev[h] = off;
    lv_head[lv] = off;
  endfunction

  function automatic void lst_back(int unsigned lv, int unsigned off);
    int unsigned t;
    t = lv_tail[lv];
    sh_next[off] = NIL;
    sh_prev[off] = t;
    if (t == NIL) lv_head[lv] = off;
    else sh_next[t] = off;
    lv_tail[lv] = off;
  endfunction

  function automatic void mark(int unsigned off, bit st, bit fr, int unsigned lv);
    sh_start[off] = st;
    sh_free[off] = fr;
    sh_lg[off] = lv;
  endfunction

  function automatic void halve(int unsigned lv, int unsigned off);
    int unsigned right;
    right = off + (1 << (lv - 1));
    lst_unlink(lv, off);
    mark(off, 1, 1, lv - 1);
    mark(right, 1, 1, lv - 1);
    lst_front(lv - 1, off);
    lst_front(lv - 1, right);
  endfunction

  function automatic void claim(int unsigned lv, int unsigned off);
    lst_unlink(lv, off);
    mark(off, 1, 0, lv);
  endfunction

  function automatic int unsigned sat_up(int unsigned a, int unsigned b);
    return (a + b > 8191) ? 8191 : a + b;
  endfunction

  function automatic int unsigned sat_dn(int unsigned a, int unsigned b);
    return (b > a) ? 0 : a - b;
  endfunction

  function automatic void push_grant(logic [1:0] st, int unsigned off, int unsigned lv,
                                     bit lst);
    grant_t g;
    g.status = st;
    g.offset = OFF_W'(off);
    g.lg = LV_W'(lv);
    g.last = lst;
    g.req_tot = CNT_W'(req_cnt);
    g.alloc_tot = CNT_W'(alloc_cnt);
    expected_grants.insert(expected_grants.size(), g);
  endfunction

  function automatic void model_reset();
    for (int i = 0; i < TOTAL_UNITS; i++) begin
      mark(i, 0, 0, 0);
      sh_next[i] = NIL;
      sh_prev[i] = NIL;
    end
    for (int i = 0; i < LEVELS; i++) begin
      lv_head[i] = NIL;
      lv_tail[i] = NIL;
    end
    mark(0, 1, 1, LOG_TOTAL);
    lv_head[LOG_TOTAL] = 0;
    lv_tail[LOG_TOTAL] = 0;
    req_cnt = 0;
    alloc_cnt = 0;
    half_en = 1;
    tq_en = 1;
  endfunction

  // predicts the grants and records live blocks for later frees
  function automatic void model_alloc(int unsigned size);
    int unsigned lv, off, q;
    live_blk_t b;
    if (size == 0) begin
      push_grant(STAT_NOMEM, 0, 0, 1);
      return;
    end
    for (lv = 0; lv <= LOG_TOTAL; lv++)
      if ((1 << lv) >= size && lv_head[lv] != NIL) break;
    if (lv > LOG_TOTAL) begin
      push_grant(STAT_NOMEM, 0, 0, 1);
      return;
    end
    off = lv_head[lv];
    forever begin
      if (half_en && lv >= 1 && (1 << lv) >= 2 * size) begin
        halve(lv, off);
        lv--;
      end else if (tq_en && lv >= 2 && 3 * (1 << lv) >= 4 * size) begin
        q = off + (1 << (lv - 1));
        halve(lv, off);
        halve(lv - 1, q);
        claim(lv - 1, off);
        claim(lv - 2, q);
        req_cnt = sat_up(req_cnt, size);
        alloc_cnt = sat_up(alloc_cnt, 1 << (lv - 1));
        alloc_cnt = sat_up(alloc_cnt, 1 << (lv - 2));
        push_grant(STAT_GRANT, off, lv - 1, 0);
        push_grant(STAT_GRANT, q, lv - 2, 1);
        b = '{off, lv - 1, size, 0};
        live_blocks.insert(live_blocks.size(), b);
        b = '{q, lv - 2, size, 1};
        live_blocks.insert(live_blocks.size(), b);
        return;
      end else begin
        claim(lv, off);
        req_cnt = sat_up(req_cnt, size);
        alloc_cnt = sat_up(alloc_cnt, 1 << lv);
        push_grant(STAT_GRANT, off, lv, 1);
        b = '{off, lv, size, 1};
        live_blocks.insert(live_blocks.size(), b);
        return;
      end
    end
  endfunction

  function automatic void model_free(int unsigned size, int unsigned off, int unsigned lv,
                                     bit lst);
    int unsigned buddy, lo, hi;
    bit ok;
    ok = lv <= LOG_TOTAL && off < TOTAL_UNITS;
    if (ok) ok = (off & ((1 << lv) - 1)) == 0;
    if (ok) ok = sh_start[off] && !sh_free[off] && sh_lg[off] == lv;
    if (ok) begin
      alloc_cnt = sat_dn(alloc_cnt, 1 << lv);
      if (lst) req_cnt = sat_dn(req_cnt, size);
      mark(off, 1, 1, lv);
      lst_back(lv, off);
      while (lv < LOG_TOTAL) begin
        buddy = off ^ (1 << lv);
        if (!sh_start[buddy] || !sh_free[buddy] || sh_lg[buddy] != lv) break;
        lst_unlink(lv, off);
        lst_unlink(lv, buddy);
        lo = off < buddy ? off : buddy;
        hi = off < buddy ? buddy : off;
        mark(hi, 0, 0, 0);
        mark(lo, 1, 1, lv + 1);
        lst_front(lv + 1, lo);
        off = lo;
        lv++;
      end
    end
    push_grant(STAT_FREED, 0, 0, 1);
  endfunction

  // ---------------- drivers ----------------
  initial begin
    req_if.valid = 1'b0;
    req_if.operation = OP_ALLOC;
    req_if.req_units = '0;
    req_if.block_offset = '0;
    req_if.block_log_size = '0;
    req_if.last_block = 1'b0;
    rsp_if.ready = 1'b0;
  end

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  task automatic idle_cycles(int unsigned n);
    repeat (n) @(posedge clk_i);
  endtask

  // valid stays high into a back-to-back transaction, dropped before any gap
  task automatic send_item(bit op, int unsigned size, int unsigned off, int unsigned lv,
                           bit lst);
    int unsigned n;
    n = sweep ? 0 : gap_len();
    if (n != 0) begin
      req_if.valid <= 1'b0;
      idle_cycles(n);
    end
    req_if.valid <= 1'b1;
    req_if.operation <= op;
    req_if.req_units <= SIZE_W'(size);
    req_if.block_offset <= OFF_W'(off);
    req_if.block_log_size <= LV_W'(lv);
    req_if.last_block <= lst;
    do @(posedge clk_i); while (!req_if.ready);
    if (op == OP_ALLOC) model_alloc(size);
    else model_free(size, off, lv, lst);
  endtask

  task automatic req_release();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic alloc(int unsigned size);
    send_item(OP_ALLOC, size, $urandom_range(0, 4095), $urandom_range(0, 15),
              1'($urandom()));
  endtask

  // frees one random live block
  task automatic free_live();
    int unsigned i;
    live_blk_t b;
    i = $urandom_range(0, live_blocks.size() - 1);
    b = live_blocks[i];
    live_blocks.delete(i);
    send_item(OP_FREE, b.size, b.off, b.lg, b.last);
  endtask

  task automatic reg_write(logic rg, bit val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({rg, 2'b00});
    pwdata <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (rg == REG_HALF_SPLIT) half_en = val;
    else tq_en = val;
  endtask

  task automatic drain();
    req_release();
    while (expected_grants.size() != 0) @(posedge clk_i);
    idle_cycles(200);
  endtask

  task automatic set_modes(bit h, bit t);
    drain();
    reg_write(REG_HALF_SPLIT, h);
    reg_write(REG_THREE_QTR, t);
  endtask

  task automatic free_all();
    while (live_blocks.size() != 0) free_live();
  endtask

  // ---------------- result checking ----------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        grant_t got, exp_g;
        got = '{rsp_if.status, rsp_if.granted_offset, rsp_if.granted_log_size, rsp_if.last,
                rsp_if.requested_total, rsp_if.allocated_total};
        if (expected_grants.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected transaction %p", got);
        end else begin
          exp_g = expected_grants.pop_front();
          if (got !== exp_g) begin
            errors++;
            if (mismatches++ < 10) $display("mismatch: expected %p got %p", exp_g, got);
          end
        end
      end
      rsp_if.ready <= rsp_hold ? 1'b0 : ($urandom_range(0, 3) != 0 ||
                                          $urandom_range(0, 1) == 0);
    end
  end

  // ---------------- tests ----------------
  task automatic test_directed();
    alloc(0);
    alloc(4096);
    alloc(4097);
    alloc(8191);
    alloc(1);
    alloc(3);
    alloc(5);
    alloc(1000);
    send_item(OP_FREE, 5, 4095, 0, 1);          // never allocated
    send_item(OP_FREE, 5, 3, 2, 1);             // misaligned
    send_item(OP_FREE, 5, 0, 13, 1);            // log size too big
    send_item(OP_FREE, 5, 0, 15, 1);
    send_item(OP_FREE, 5, 0, 5, 1);             // wrong size
    alloc(2048);
    free_live();
    free_live();
    send_item(OP_FREE, 1, 0, 0, 1);             // possibly double free
    free_all();
    set_modes(0, 1);
    alloc(4);
    alloc(2);
    free_all();
    set_modes(0, 0);
    alloc(1);
    alloc(4096);
    free_all();
    set_modes(1, 0);
    alloc(3);
    free_all();
    set_modes(1, 1);
  endtask

  task automatic test_random(int unsigned n);
    int unsigned sz;
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 149) set_modes(1'($urandom()), 1'($urandom()));
      case ($urandom_range(0, 9))
        0: alloc($urandom_range(0, 8191));
        1, 2: alloc($urandom_range(1, 4096));
        3, 4, 5: begin
          sz = $urandom_range(1, 64);
          alloc(sz);
        end
        6, 7, 8: if (live_blocks.size() != 0) free_live(); else alloc(1);
        default: send_item(OP_FREE, $urandom_range(0, 8191), $urandom_range(0, 4095),
                           $urandom_range(0, 15), 1'($urandom()));
      endcase
    end
    free_all();
  endtask

  // results are held back while the sender keeps offering allocates
  task automatic test_backpressure();
    sweep = 1'b1;
    fork
      begin
        rsp_hold = 1'b1;
        idle_cycles(3000);
        rsp_hold = 1'b0;
      end
      begin
        for (int i = 0; i < 20; i++) alloc($urandom_range(1, 16));
        req_release();
      end
    join
    sweep = 1'b0;
    free_all();
  endtask

  initial begin
    model_reset();
    idle_cycles(11);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_random(560);
    drain();
    if (errors == 0 && expected_grants.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/core/balloc_pkg.sv
rtl/core/balloc_req_if.sv
rtl/core/balloc_rsp_if.sv
rtl/core/balloc_dp.sv
rtl/core/balloc_ctrl.sv
rtl/core/buddy_allocator_three_quarter.sv
sim/tb_top.sv
